>>> design/ffra_pkg.sv
// ----------------------------------------------------------------------------
// First-fit range allocator package
// Shared types and fixed field widths for the first-fit range allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffra_pkg;

  // Fixed field widths of the request, response and configuration ports.
  localparam int COUNT_W  = 21;
  localparam int HANDLE_W = 4;
  localparam int CAP_W    = 21;

  // Buffer capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 21'h100000;

  // Request function codes.
  localparam logic FUNC_OBTAIN  = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_WALK,
    ST_APP_CHK,
    ST_WR_NEW,
    ST_WR_CUR,
    ST_WR_PREV,
    ST_REL_RD,
    ST_REL_N,
    ST_RESULT
  } state_e;

  // Where a new slice is placed.
  typedef enum logic [1:0] {
    PLACE_EMPTY,
    PLACE_GAP,
    PLACE_APPEND
  } place_mode_e;

  // Field write enables of the slice table.
  typedef struct packed {
    logic data;
    logic next;
    logic prev;
  } tbl_we_t;

  // One response transaction.
  typedef struct packed {
    logic                ok;
    logic [COUNT_W-1:0]  slice_offset;
    logic [HANDLE_W-1:0] slice_handle;
    logic                now_empty;
  } rsp_t;

endpackage

`default_nettype wire

>>> design/ffra_req_if.sv
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel that carries obtain and release requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ffra_req_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [ffra_pkg::COUNT_W-1:0]  request_count;
  logic [ffra_pkg::HANDLE_W-1:0] release_handle;

  modport source (output valid, func, request_count, release_handle, input ready);
  modport sink   (input valid, func, request_count, release_handle, output ready);
endinterface

`default_nettype wire

>>> design/ffra_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel that carries one result per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ffra_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [ffra_pkg::COUNT_W-1:0]  slice_offset;
  logic [ffra_pkg::HANDLE_W-1:0] slice_handle;
  logic                          now_empty;

  modport source (output valid, ok, slice_offset, slice_handle, now_empty, input ready);
  modport sink   (input valid, ok, slice_offset, slice_handle, now_empty, output ready);
endinterface

`default_nettype wire

>>> design/ffra_alu.sv
// ----------------------------------------------------------------------------
// Shared add and compare unit
// Forms a + b and tells whether the sum does not exceed a limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffra_alu #(
  parameter int WIDTH = 23
) (
  input  wire logic [WIDTH-1:0] a_i,
  input  wire logic [WIDTH-1:0] b_i,
  input  wire logic [WIDTH-1:0] lim_i,
  output logic      [WIDTH-1:0] sum_o,
  output logic                  le_o
);

  // The operand widths leave headroom, so the sum never wraps.
  assign sum_o = a_i + b_i;
  assign le_o  = (sum_o <= lim_i);

endmodule

`default_nettype wire

>>> design/ffra_table.sv
// ----------------------------------------------------------------------------
// Slice table
// Linked slice records in memory with one read and one write port, plus the
// live bits and the lowest-free-slot encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffra_table #(
  parameter int MAX_SLICES = 16,
  parameter int UNIT_BITS  = 21,
  localparam int IW = $clog2(MAX_SLICES)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Read port, data in the cycle after the address.
  input  wire logic [IW-1:0]     rd_addr_i,
  output logic [UNIT_BITS-1:0]   rd_start_o,
  output logic [UNIT_BITS:0]     rd_end_o,
  output logic [IW-1:0]          rd_next_o,
  output logic                   rd_has_next_o,
  output logic [IW-1:0]          rd_prev_o,
  output logic                   rd_has_prev_o,
  // Write port with field enables.
  input  wire logic [IW-1:0]     wr_addr_i,
  input  wire ffra_pkg::tbl_we_t wr_en_i,
  input  wire logic [UNIT_BITS-1:0] wr_start_i,
  input  wire logic [UNIT_BITS:0]   wr_end_i,
  input  wire logic [IW-1:0]     wr_next_i,
  input  wire logic              wr_has_next_i,
  input  wire logic [IW-1:0]     wr_prev_i,
  input  wire logic              wr_has_prev_i,
  // Live bits.
  input  wire logic              live_set_i,
  input  wire logic              live_clr_i,
  input  wire logic [IW-1:0]     live_addr_i,
  output logic [MAX_SLICES-1:0]  live_o,
  output logic                   free_found_o,
  output logic [IW-1:0]          free_idx_o
);

  logic [UNIT_BITS-1:0] mem_start [MAX_SLICES];
  logic [UNIT_BITS:0]   mem_end   [MAX_SLICES];
  logic [IW:0]          mem_next  [MAX_SLICES];
  logic [IW:0]          mem_prev  [MAX_SLICES];
  logic [IW:0]          rd_next_q;
  logic [IW:0]          rd_prev_q;
  logic [MAX_SLICES-1:0] live_q;

  // Memory write, one address per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en_i.data) begin
      mem_start[wr_addr_i] <= wr_start_i;
      mem_end[wr_addr_i]   <= wr_end_i;
    end
    if (wr_en_i.next) begin
      mem_next[wr_addr_i] <= {wr_has_next_i, wr_next_i};
    end
    if (wr_en_i.prev) begin
      mem_prev[wr_addr_i] <= {wr_has_prev_i, wr_prev_i};
    end
  end

  // Registered memory read.
  always_ff @(posedge clk_i) begin
    rd_start_o <= mem_start[rd_addr_i];
    rd_end_o   <= mem_end[rd_addr_i];
    rd_next_q  <= mem_next[rd_addr_i];
    rd_prev_q  <= mem_prev[rd_addr_i];
  end

  assign rd_next_o     = rd_next_q[IW-1:0];
  assign rd_has_next_o = rd_next_q[IW];
  assign rd_prev_o     = rd_prev_q[IW-1:0];
  assign rd_has_prev_o = rd_prev_q[IW];

  // Live bits are cleared at once by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else if (live_set_i) begin
      live_q[live_addr_i] <= 1'b1;
    end else if (live_clr_i) begin
      live_q[live_addr_i] <= 1'b0;
    end
  end

  assign live_o = live_q;

  // Lowest slot that is not live.
  always_comb begin
    free_found_o = 1'b0;
    free_idx_o   = '0;
    for (int i = MAX_SLICES - 1; i >= 0; i--) begin
      if (!live_q[i]) begin
        free_found_o = 1'b1;
        free_idx_o   = IW'(i);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/ffra_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator sequencer
// Walks the slice list one record per cycle through the shared add and
// compare unit, then links or unlinks records one table write per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffra_ctrl #(
  parameter int MAX_SLICES = 16,
  parameter int UNIT_BITS  = 21,
  localparam int IW = $clog2(MAX_SLICES),
  localparam int CW = ((UNIT_BITS > ffra_pkg::COUNT_W) ? UNIT_BITS : ffra_pkg::COUNT_W) + 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Request side.
  input  wire logic                          req_valid_i,
  output logic                               req_ready_o,
  input  wire logic                          req_func_i,
  input  wire logic [ffra_pkg::COUNT_W-1:0]  req_count_i,
  input  wire logic [ffra_pkg::HANDLE_W-1:0] req_handle_i,
  input  wire logic [ffra_pkg::CAP_W-1:0]    capacity_i,
  // Result side.
  input  wire logic                          rsp_free_i,
  output logic                               res_push_o,
  output ffra_pkg::rsp_t                     res_o,
  // Table.
  output logic [IW-1:0]                      rd_addr_o,
  input  wire logic [UNIT_BITS-1:0]          rd_start_i,
  input  wire logic [UNIT_BITS:0]            rd_end_i,
  input  wire logic [IW-1:0]                 rd_next_i,
  input  wire logic                          rd_has_next_i,
  input  wire logic [IW-1:0]                 rd_prev_i,
  input  wire logic                          rd_has_prev_i,
  output logic [IW-1:0]                      wr_addr_o,
  output ffra_pkg::tbl_we_t                  wr_en_o,
  output logic [UNIT_BITS-1:0]               wr_start_o,
  output logic [UNIT_BITS:0]                 wr_end_o,
  output logic [IW-1:0]                      wr_next_o,
  output logic                               wr_has_next_o,
  output logic [IW-1:0]                      wr_prev_o,
  output logic                               wr_has_prev_o,
  output logic                               live_set_o,
  output logic                               live_clr_o,
  output logic [IW-1:0]                      live_addr_o,
  input  wire logic [MAX_SLICES-1:0]         live_i,
  input  wire logic                          free_found_i,
  input  wire logic [IW-1:0]                 free_idx_i,
  // Shared add and compare unit.
  output logic [CW-1:0]                      alu_a_o,
  output logic [CW-1:0]                      alu_b_o,
  output logic [CW-1:0]                      alu_lim_o,
  input  wire logic [CW-1:0]                 alu_sum_i,
  input  wire logic                          alu_le_i
);

  localparam logic [CW-1:0] UNIT_MASK = {{(CW-UNIT_BITS){1'b0}}, {UNIT_BITS{1'b1}}};

  ffra_pkg::state_e      state_q, state_d;
  ffra_pkg::place_mode_e mode_q, mode_d;
  logic                  head_vld_q, head_vld_d;
  logic [IW-1:0]         head_q, head_d;

  logic                          func_q, func_d;
  logic [ffra_pkg::COUNT_W-1:0]  count_q, count_d;
  logic [ffra_pkg::HANDLE_W-1:0] handle_q, handle_d;
  logic [UNIT_BITS:0]            offset_q, offset_d;
  logic [UNIT_BITS:0]            place_off_q, place_off_d;
  logic [IW-1:0]                 cur_q, cur_d;
  logic [IW-1:0]                 slot_q, slot_d;
  logic [IW-1:0]                 rec_next_q, rec_next_d;
  logic                          rec_hn_q, rec_hn_d;
  logic [IW-1:0]                 rec_prev_q, rec_prev_d;
  logic                          rec_hp_q, rec_hp_d;
  ffra_pkg::rsp_t                res_q, res_d;

  logic [31:0]   h_ext;
  logic          h_valid;
  logic [IW-1:0] h_idx;
  logic [31:0]   slot_ext;
  logic [CW-1:0] off_masked;
  logic          obtain;

  // Release handle decode and result field formatting.
  assign h_ext      = 32'(handle_q);
  assign h_valid    = (h_ext < 32'(MAX_SLICES)) && live_i[h_ext[IW-1:0]];
  assign h_idx      = h_ext[IW-1:0];
  assign slot_ext   = 32'(slot_q);
  assign off_masked = CW'(place_off_q) & UNIT_MASK;
  assign obtain     = (func_q == ffra_pkg::FUNC_OBTAIN);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ffra_pkg::ST_IDLE: begin
        if (req_valid_i) state_d = ffra_pkg::ST_START;
      end
      ffra_pkg::ST_START: begin
        if (obtain) begin
          if (!free_found_i) state_d = ffra_pkg::ST_RESULT;
          else if (!head_vld_q) state_d = alu_le_i ? ffra_pkg::ST_WR_NEW : ffra_pkg::ST_RESULT;
          else state_d = ffra_pkg::ST_WALK;
        end else begin
          state_d = h_valid ? ffra_pkg::ST_REL_RD : ffra_pkg::ST_RESULT;
        end
      end
      ffra_pkg::ST_WALK: begin
        if (alu_le_i) state_d = ffra_pkg::ST_WR_NEW;
        else if (!rd_has_next_i) state_d = ffra_pkg::ST_APP_CHK;
      end
      ffra_pkg::ST_APP_CHK: begin
        state_d = alu_le_i ? ffra_pkg::ST_WR_NEW : ffra_pkg::ST_RESULT;
      end
      ffra_pkg::ST_WR_NEW: begin
        state_d = (mode_q == ffra_pkg::PLACE_EMPTY) ? ffra_pkg::ST_RESULT : ffra_pkg::ST_WR_CUR;
      end
      ffra_pkg::ST_WR_CUR: begin
        state_d = (mode_q == ffra_pkg::PLACE_GAP && rec_hp_q) ? ffra_pkg::ST_WR_PREV
                                                               : ffra_pkg::ST_RESULT;
      end
      ffra_pkg::ST_WR_PREV: state_d = ffra_pkg::ST_RESULT;
      ffra_pkg::ST_REL_RD:  state_d = ffra_pkg::ST_REL_N;
      ffra_pkg::ST_REL_N:   state_d = ffra_pkg::ST_RESULT;
      ffra_pkg::ST_RESULT: begin
        if (rsp_free_i) state_d = ffra_pkg::ST_IDLE;
      end
      default: state_d = ffra_pkg::ST_IDLE;
    endcase
  end

  // Outputs to the table, the shared unit and the result register.
  always_comb begin
    req_ready_o   = (state_q == ffra_pkg::ST_IDLE);
    res_push_o    = 1'b0;
    rd_addr_o     = cur_q;
    wr_addr_o     = slot_q;
    wr_en_o       = '0;
    wr_start_o    = place_off_q[UNIT_BITS-1:0];
    wr_end_o      = alu_sum_i[UNIT_BITS:0];
    wr_next_o     = '0;
    wr_has_next_o = 1'b0;
    wr_prev_o     = '0;
    wr_has_prev_o = 1'b0;
    live_set_o    = 1'b0;
    live_clr_o    = 1'b0;
    live_addr_o   = slot_q;
    alu_a_o       = CW'(offset_q);
    alu_b_o       = CW'(count_q);
    alu_lim_o     = CW'(rd_start_i);
    unique case (state_q)
      ffra_pkg::ST_START: begin
        rd_addr_o = obtain ? head_q : h_idx;
        alu_a_o   = '0;
        alu_lim_o = CW'(capacity_i);
      end
      ffra_pkg::ST_WALK: begin
        rd_addr_o = rd_next_i;
      end
      ffra_pkg::ST_APP_CHK: begin
        alu_lim_o = CW'(capacity_i);
      end
      ffra_pkg::ST_WR_NEW: begin
        // The end of the new record is formed from the stored start and length.
        alu_a_o    = off_masked;
        alu_b_o    = CW'(count_q) & UNIT_MASK;
        wr_en_o    = '{data: 1'b1, next: 1'b1, prev: 1'b1};
        live_set_o = 1'b1;
        unique case (mode_q)
          ffra_pkg::PLACE_GAP: begin
            wr_next_o     = cur_q;
            wr_has_next_o = 1'b1;
            wr_prev_o     = rec_prev_q;
            wr_has_prev_o = rec_hp_q;
          end
          ffra_pkg::PLACE_APPEND: begin
            wr_prev_o     = cur_q;
            wr_has_prev_o = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ffra_pkg::ST_WR_CUR: begin
        wr_addr_o = cur_q;
        if (mode_q == ffra_pkg::PLACE_GAP) begin
          wr_en_o.prev  = 1'b1;
          wr_prev_o     = slot_q;
          wr_has_prev_o = 1'b1;
        end else begin
          wr_en_o.next  = 1'b1;
          wr_next_o     = slot_q;
          wr_has_next_o = 1'b1;
        end
      end
      ffra_pkg::ST_WR_PREV: begin
        wr_addr_o     = rec_prev_q;
        wr_en_o.next  = 1'b1;
        wr_next_o     = slot_q;
        wr_has_next_o = 1'b1;
      end
      ffra_pkg::ST_REL_RD: begin
        // Point the predecessor past the released record.
        wr_addr_o     = rd_prev_i;
        wr_en_o.next  = rd_has_prev_i;
        wr_next_o     = rd_next_i;
        wr_has_next_o = rd_has_next_i;
      end
      ffra_pkg::ST_REL_N: begin
        // Point the successor back past the released record.
        wr_addr_o     = rec_next_q;
        wr_en_o.prev  = rec_hn_q;
        wr_prev_o     = rec_prev_q;
        wr_has_prev_o = rec_hp_q;
        live_clr_o    = 1'b1;
        live_addr_o   = h_idx;
      end
      ffra_pkg::ST_RESULT: begin
        res_push_o = rsp_free_i;
      end
      default: begin
      end
    endcase
  end

  // Working registers and list head.
  always_comb begin
    func_d      = func_q;
    count_d     = count_q;
    handle_d    = handle_q;
    offset_d    = offset_q;
    place_off_d = place_off_q;
    cur_d       = cur_q;
    slot_d      = slot_q;
    mode_d      = mode_q;
    rec_next_d  = rec_next_q;
    rec_hn_d    = rec_hn_q;
    rec_prev_d  = rec_prev_q;
    rec_hp_d    = rec_hp_q;
    res_d       = res_q;
    head_d      = head_q;
    head_vld_d  = head_vld_q;
    unique case (state_q)
      ffra_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          func_d   = req_func_i;
          count_d  = req_count_i;
          handle_d = req_handle_i;
        end
      end
      ffra_pkg::ST_START: begin
        slot_d      = free_idx_i;
        offset_d    = '0;
        place_off_d = '0;
        cur_d       = head_q;
        mode_d      = ffra_pkg::PLACE_EMPTY;
        res_d       = '0;
        if (obtain) begin
          res_d.now_empty = free_found_i && !head_vld_q;
        end else begin
          res_d.now_empty = !head_vld_q;
        end
      end
      ffra_pkg::ST_WALK: begin
        if (alu_le_i) begin
          place_off_d = offset_q;
          mode_d      = ffra_pkg::PLACE_GAP;
          rec_prev_d  = rd_prev_i;
          rec_hp_d    = rd_has_prev_i;
        end else begin
          offset_d = rd_end_i;
          if (rd_has_next_i) cur_d = rd_next_i;
        end
      end
      ffra_pkg::ST_APP_CHK: begin
        place_off_d = offset_q;
        mode_d      = ffra_pkg::PLACE_APPEND;
      end
      ffra_pkg::ST_WR_NEW: begin
        res_d.ok           = 1'b1;
        res_d.slice_offset = off_masked[ffra_pkg::COUNT_W-1:0];
        res_d.slice_handle = slot_ext[ffra_pkg::HANDLE_W-1:0];
        res_d.now_empty    = 1'b0;
        if (mode_q == ffra_pkg::PLACE_EMPTY) begin
          head_d     = slot_q;
          head_vld_d = 1'b1;
        end
      end
      ffra_pkg::ST_WR_CUR: begin
        if (mode_q == ffra_pkg::PLACE_GAP && !rec_hp_q) head_d = slot_q;
      end
      ffra_pkg::ST_REL_RD: begin
        rec_next_d = rd_next_i;
        rec_hn_d   = rd_has_next_i;
        rec_prev_d = rd_prev_i;
        rec_hp_d   = rd_has_prev_i;
        if (!rd_has_prev_i) begin
          head_d     = rd_next_i;
          head_vld_d = rd_has_next_i;
        end
      end
      ffra_pkg::ST_REL_N: begin
        res_d.ok           = 1'b1;
        res_d.slice_offset = '0;
        res_d.slice_handle = '0;
        res_d.now_empty    = !head_vld_q;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ffra_pkg::ST_IDLE;
      head_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_vld_q <= head_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    head_q      <= head_d;
    mode_q      <= mode_d;
    func_q      <= func_d;
    count_q     <= count_d;
    handle_q    <= handle_d;
    offset_q    <= offset_d;
    place_off_q <= place_off_d;
    cur_q       <= cur_d;
    slot_q      <= slot_d;
    rec_next_q  <= rec_next_d;
    rec_hn_q    <= rec_hn_d;
    rec_prev_q  <= rec_prev_d;
    rec_hp_q    <= rec_hp_d;
    res_q       <= res_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

>>> design/first_fit_range_allocator_core.sv
// ----------------------------------------------------------------------------
// First-fit range allocator core
// Sub-allocates ranges of a buffer of configured capacity from a linked
// table of slices kept in offset order.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake      Transaction
//   req_i    in         valid/ready    func, request_count, release_handle
//   rsp_o    out        valid/ready    ok, slice_offset, slice_handle, now_empty
//   cfg      in         cfg_we_i       buffer_capacity (cfg_wdata_i)
//
// An obtain reads the records of its walk one per cycle through the memory
// read port (at most MAX_SLICES - 1), then writes the new record, the current
// record and, in a gap with a predecessor, the previous record.
// On an empty list an obtain skips the walk; on a full table it fails without a walk.
// A release relinks both neighbours; a handle that is not live fails.
// Reset clears the live bits and the list head at once; no clearing pass.
// The request side stays busy until the result is loaded into the output
// register; a stalled response holds the next request in ST_RESULT.
//
`timescale 1ns / 1ps
`default_nettype none

module first_fit_range_allocator_core #(
  parameter int MAX_SLICES = 16,
  parameter int UNIT_BITS  = 21
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  ffra_req_if.sink                        req_i,
  ffra_rsp_if.source                      rsp_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [ffra_pkg::CAP_W-1:0] cfg_wdata_i
);

  localparam int IW = $clog2(MAX_SLICES);
  localparam int CW = ((UNIT_BITS > ffra_pkg::COUNT_W) ? UNIT_BITS : ffra_pkg::COUNT_W) + 2;

  logic [ffra_pkg::CAP_W-1:0] capacity_q;
  logic                       rsp_valid_q;
  ffra_pkg::rsp_t             rsp_q;
  logic                       rsp_free;
  logic                       res_push;
  ffra_pkg::rsp_t             res;

  logic [IW-1:0]         rd_addr;
  logic [UNIT_BITS-1:0]  rd_start;
  logic [UNIT_BITS:0]    rd_end;
  logic [IW-1:0]         rd_next;
  logic                  rd_has_next;
  logic [IW-1:0]         rd_prev;
  logic                  rd_has_prev;
  logic [IW-1:0]         wr_addr;
  ffra_pkg::tbl_we_t     wr_en;
  logic [UNIT_BITS-1:0]  wr_start;
  logic [UNIT_BITS:0]    wr_end;
  logic [IW-1:0]         wr_next;
  logic                  wr_has_next;
  logic [IW-1:0]         wr_prev;
  logic                  wr_has_prev;
  logic                  live_set;
  logic                  live_clr;
  logic [IW-1:0]         live_addr;
  logic [MAX_SLICES-1:0] live;
  logic                  free_found;
  logic [IW-1:0]         free_idx;
  logic [CW-1:0]         alu_a;
  logic [CW-1:0]         alu_b;
  logic [CW-1:0]         alu_lim;
  logic [CW-1:0]         alu_sum;
  logic                  alu_le;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= ffra_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  // Output register for the response transaction.
  assign rsp_free = !rsp_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (res_push) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) rsp_q <= res;
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.ok           = rsp_q.ok;
  assign rsp_o.slice_offset = rsp_q.slice_offset;
  assign rsp_o.slice_handle = rsp_q.slice_handle;
  assign rsp_o.now_empty    = rsp_q.now_empty;

  ffra_ctrl #(
    .MAX_SLICES (MAX_SLICES),
    .UNIT_BITS  (UNIT_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_ready_o   (req_i.ready),
    .req_func_i    (req_i.func),
    .req_count_i   (req_i.request_count),
    .req_handle_i  (req_i.release_handle),
    .capacity_i    (capacity_q),
    .rsp_free_i    (rsp_free),
    .res_push_o    (res_push),
    .res_o         (res),
    .rd_addr_o     (rd_addr),
    .rd_start_i    (rd_start),
    .rd_end_i      (rd_end),
    .rd_next_i     (rd_next),
    .rd_has_next_i (rd_has_next),
    .rd_prev_i     (rd_prev),
    .rd_has_prev_i (rd_has_prev),
    .wr_addr_o     (wr_addr),
    .wr_en_o       (wr_en),
    .wr_start_o    (wr_start),
    .wr_end_o      (wr_end),
    .wr_next_o     (wr_next),
    .wr_has_next_o (wr_has_next),
    .wr_prev_o     (wr_prev),
    .wr_has_prev_o (wr_has_prev),
    .live_set_o    (live_set),
    .live_clr_o    (live_clr),
    .live_addr_o   (live_addr),
    .live_i        (live),
    .free_found_i  (free_found),
    .free_idx_i    (free_idx),
    .alu_a_o       (alu_a),
    .alu_b_o       (alu_b),
    .alu_lim_o     (alu_lim),
    .alu_sum_i     (alu_sum),
    .alu_le_i      (alu_le)
  );

  ffra_table #(
    .MAX_SLICES (MAX_SLICES),
    .UNIT_BITS  (UNIT_BITS)
  ) u_table (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_addr_i     (rd_addr),
    .rd_start_o    (rd_start),
    .rd_end_o      (rd_end),
    .rd_next_o     (rd_next),
    .rd_has_next_o (rd_has_next),
    .rd_prev_o     (rd_prev),
    .rd_has_prev_o (rd_has_prev),
    .wr_addr_i     (wr_addr),
    .wr_en_i       (wr_en),
    .wr_start_i    (wr_start),
    .wr_end_i      (wr_end),
    .wr_next_i     (wr_next),
    .wr_has_next_i (wr_has_next),
    .wr_prev_i     (wr_prev),
    .wr_has_prev_i (wr_has_prev),
    .live_set_i    (live_set),
    .live_clr_i    (live_clr),
    .live_addr_i   (live_addr),
    .live_o        (live),
    .free_found_o  (free_found),
    .free_idx_o    (free_idx)
  );

  ffra_alu #(
    .WIDTH (CW)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .lim_i (alu_lim),
    .sum_o (alu_sum),
    .le_o  (alu_le)
  );

endmodule

`default_nettype wire

>>> design/ffra_checker.sv
// ----------------------------------------------------------------------------
// Allocator port checker
// Concurrent assertions on the request and response ports of the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffra_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          req_valid_i,
  input wire logic                          req_ready_i,
  input wire logic                          rsp_valid_i,
  input wire logic                          rsp_ready_i,
  input wire logic                          rsp_ok_i,
  input wire logic [ffra_pkg::COUNT_W-1:0]  rsp_slice_offset_i,
  input wire logic [ffra_pkg::HANDLE_W-1:0] rsp_slice_handle_i,
  input wire logic                          rsp_now_empty_i
);

  // A request occupies the core, so it is busy right after acceptance.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request side ready right after an accepted transaction");

  // A response never appears in the cycle after a request is taken.
  a_no_instant_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !$rose(rsp_valid_i))
    else $error("response raised one cycle after a request");

  // A stalled response holds its contents.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_ok_i)
      && $stable(rsp_slice_offset_i) && $stable(rsp_slice_handle_i)
      && $stable(rsp_now_empty_i)))
    else $error("stalled response changed");

  // Failures and responses that flag an empty list report neither offset nor handle.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (!rsp_ok_i || rsp_now_empty_i))
      |-> (rsp_slice_offset_i == '0 && rsp_slice_handle_i == '0))
    else $error("offset or handle set on a failed or emptying response");

endmodule

bind first_fit_range_allocator_core ffra_checker u_ffra_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_ok_i           (rsp_o.ok),
  .rsp_slice_offset_i (rsp_o.slice_offset),
  .rsp_slice_handle_i (rsp_o.slice_handle),
  .rsp_now_empty_i    (rsp_o.now_empty)
);

`default_nettype wire
